>>> hw/rtl/sfx_pkg.sv
`default_nettype none

package sfx_pkg;

	// Operation codes carried in the tuser field of the input beat.
	typedef enum logic [1:0] {
		OP_HOST_WRITE = 2'd0,
		OP_TX_READY   = 2'd1,
		OP_LINE_RECV  = 2'd2,
		OP_HOST_READ  = 2'd3
	} op_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_XOFF_THRESHOLD = 2'd0,
		REG_XON_THRESHOLD  = 2'd1,
		REG_XOFF_CODE      = 2'd2,
		REG_XON_CODE       = 2'd3
	} reg_index_t;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned THRESH_W = 7;
	localparam int unsigned CFG_W    = 8;
	localparam int unsigned S_TDATA_W = 16;
	localparam int unsigned S_TUSER_W = 2;
	localparam int unsigned M_TDATA_W = 24;

	localparam int unsigned SEND_DEPTH_DEFAULT = 64;
	localparam int unsigned RECV_DEPTH_DEFAULT = 64;

	localparam logic [THRESH_W-1:0] XOFF_THRESHOLD_RST = 7'd40;
	localparam logic [THRESH_W-1:0] XON_THRESHOLD_RST  = 7'd10;
	localparam logic [BYTE_W-1:0]   XOFF_CODE_RST      = 8'd19;
	localparam logic [BYTE_W-1:0]   XON_CODE_RST       = 8'd17;

	// Occupancy flags a FIFO hands to the control logic.
	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/sfx_fifo.sv
`default_nettype none

// Byte FIFO with a registered read port. The read data register loads the
// head entry on the cycle the pop is taken and holds it until the next pop.
module sfx_fifo #(
	parameter int unsigned DEPTH = sfx_pkg::SEND_DEPTH_DEFAULT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	input  wire logic                          pop,
	input  wire logic [sfx_pkg::BYTE_W-1:0]    wdata,
	output logic [sfx_pkg::BYTE_W-1:0]         rdata,
	output logic [$clog2(DEPTH+1)-1:0]         count,
	output sfx_pkg::fifo_status_t              status
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH+1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	logic [sfx_pkg::BYTE_W-1:0] mem [DEPTH];
	logic [PW-1:0]              head_q;
	logic [PW-1:0]              tail_q;
	logic [CW-1:0]              count_q;
	logic [sfx_pkg::BYTE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[tail_q] <= wdata;
		end
		if (pop) begin
			rdata_q <= mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= (tail_q == LAST) ? '0 : tail_q + PW'(1);
			end
			if (pop) begin
				head_q <= (head_q == LAST) ? '0 : head_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign rdata        = rdata_q;
	assign count        = count_q;
	assign status.full  = (count_q == CW'(DEPTH));
	assign status.empty = (count_q == '0);

endmodule

`default_nettype wire

>>> hw/rtl/serial_fifos_xon_xoff_unit.sv
`default_nettype none

// Channel  | Direction | Payload (from bit 0 up)
// s_*      | in        | tdata: host_byte[7:0], line_byte[15:8]; tuser: operation[1:0]
// m_*      | out       | send_valid, send_byte, read_valid, read_byte, write_accepted,
//          |           | overflow_flag, input_available, transmit_request, zero pad
// cfg_*    | in        | cfg_addr selects the register, cfg_data carries its value
//
// One beat is taken per clock cycle when the output side keeps up. An accepted beat
// lands in the input register and moves on to the output register, where its result is
// offered, once that register is free or its result is being taken. All FIFO pointer,
// count and flow-control updates happen as the item moves on. Reset clears the pointers,
// counts and flow-control flags, turns transmit requests on and loads the default
// configuration; the byte stores are not cleared and need no pass.
// A stalled output holds both the result and the pending input beat; s_tready drops only
// while both stages are occupied and the result is not being taken.
module serial_fifos_xon_xoff_unit #(
	parameter int unsigned SEND_DEPTH = sfx_pkg::SEND_DEPTH_DEFAULT,
	parameter int unsigned RECV_DEPTH = sfx_pkg::RECV_DEPTH_DEFAULT
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Input beats.
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// host_byte[7:0], line_byte[15:8]
	input  wire logic [sfx_pkg::S_TDATA_W-1:0]   s_tdata,
	// operation[1:0]
	input  wire logic [sfx_pkg::S_TUSER_W-1:0]   s_tuser,
	// Result beats.
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// send_valid[0], send_byte[8:1], read_valid[9], read_byte[17:10],
	// write_accepted[18], overflow_flag[19], input_available[20],
	// transmit_request[21], zeros above
	output logic [sfx_pkg::M_TDATA_W-1:0]        m_tdata,
	// Configuration writes.
	input  wire logic                            cfg_we,
	input  wire logic [1:0]                      cfg_addr,
	input  wire logic [sfx_pkg::CFG_W-1:0]       cfg_data
);

	localparam int unsigned BW  = sfx_pkg::BYTE_W;
	localparam int unsigned TW  = sfx_pkg::THRESH_W;
	localparam int unsigned SCW = $clog2(SEND_DEPTH+1);
	localparam int unsigned RCW = $clog2(RECV_DEPTH+1);
	// Compare width wide enough for both the receive count and the thresholds.
	localparam int unsigned CMPW = (RCW > TW) ? RCW : TW;

	// Configuration registers.
	logic [TW-1:0] xoff_thr_q;
	logic [TW-1:0] xon_thr_q;
	logic [BW-1:0] xoff_code_q;
	logic [BW-1:0] xon_code_q;

	// Flow-control state.
	logic          urgent_valid_q;
	logic [BW-1:0] urgent_value_q;
	logic          sender_active_q;
	logic          resume_sent_q;

	// Input register.
	logic          valid_s1;
	sfx_pkg::op_t  op_s1;
	logic [BW-1:0] host_byte_s1;
	logic [BW-1:0] line_byte_s1;

	// Output register; the returned bytes come from the FIFO read registers or the urgent byte.
	logic valid_s2;
	logic send_valid_s2;
	logic read_valid_s2;
	logic write_acc_s2;
	logic overflow_s2;
	logic avail_s2;
	logic tx_req_s2;

	logic advance;

	// FIFO connections.
	logic                  send_push, send_pop;
	logic                  recv_push, recv_pop;
	logic [BW-1:0]         send_rdata, recv_rdata;
	logic [SCW-1:0]        send_count;
	logic [RCW-1:0]        recv_count;
	sfx_pkg::fifo_status_t send_status, recv_status;

	// Next-state values from the combinational step.
	logic          urgent_valid_d;
	logic [BW-1:0] urgent_value_d;
	logic          sender_active_d;
	logic          resume_sent_d;
	logic          send_valid_d;
	logic          read_valid_d;
	logic          write_acc_d;
	logic          overflow_d;
	logic          avail_d;

	logic [CMPW-1:0] recv_cnt_up;
	logic [CMPW-1:0] recv_cnt_dn;

	// The item in the input register moves on whenever the output register is free
	// or its result is being taken this cycle.
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xoff_thr_q  <= sfx_pkg::XOFF_THRESHOLD_RST;
			xon_thr_q   <= sfx_pkg::XON_THRESHOLD_RST;
			xoff_code_q <= sfx_pkg::XOFF_CODE_RST;
			xon_code_q  <= sfx_pkg::XON_CODE_RST;
		end else if (cfg_we) begin
			unique case (sfx_pkg::reg_index_t'(cfg_addr))
				sfx_pkg::REG_XOFF_THRESHOLD: xoff_thr_q  <= cfg_data[TW-1:0];
				sfx_pkg::REG_XON_THRESHOLD:  xon_thr_q   <= cfg_data[TW-1:0];
				sfx_pkg::REG_XOFF_CODE:      xoff_code_q <= cfg_data[BW-1:0];
				sfx_pkg::REG_XON_CODE:       xon_code_q  <= cfg_data[BW-1:0];
				default:                     xon_code_q  <= xon_code_q;
			endcase
		end
	end

	// Input register: the valid bit is control, the payload loads on acceptance only.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1        <= sfx_pkg::op_t'(s_tuser);
			host_byte_s1 <= s_tdata[7:0];
			line_byte_s1 <= s_tdata[15:8];
		end
	end

	// Receive count after a push or a pop, used for the threshold checks.
	assign recv_cnt_up = CMPW'(recv_count) + CMPW'(1);
	assign recv_cnt_dn = CMPW'(recv_count) - CMPW'(1);

	always_comb begin
		send_push       = 1'b0;
		send_pop        = 1'b0;
		recv_push       = 1'b0;
		recv_pop        = 1'b0;
		urgent_valid_d  = urgent_valid_q;
		urgent_value_d  = urgent_value_q;
		sender_active_d = sender_active_q;
		resume_sent_d   = resume_sent_q;
		send_valid_d    = 1'b0;
		read_valid_d    = 1'b0;
		write_acc_d     = 1'b0;
		overflow_d      = 1'b0;
		avail_d         = !recv_status.empty;

		unique case (op_s1)
			sfx_pkg::OP_HOST_WRITE: begin
				if (!send_status.full) begin
					send_push       = advance;
					sender_active_d = 1'b1;
					write_acc_d     = 1'b1;
				end
			end
			sfx_pkg::OP_TX_READY: begin
				// A pending flow-control byte overtakes the queue.
				if (urgent_valid_q) begin
					send_valid_d   = 1'b1;
					urgent_valid_d = 1'b0;
				end else if (!send_status.empty) begin
					send_valid_d = 1'b1;
					send_pop     = advance;
				end else begin
					sender_active_d = 1'b0;
				end
			end
			sfx_pkg::OP_LINE_RECV: begin
				if (recv_status.full) begin
					overflow_d = 1'b1;
				end else begin
					recv_push = advance;
					avail_d   = 1'b1;
					if (recv_cnt_up > CMPW'(xoff_thr_q)) begin
						urgent_valid_d  = 1'b1;
						urgent_value_d  = xoff_code_q;
						sender_active_d = 1'b1;
					end
				end
			end
			sfx_pkg::OP_HOST_READ: begin
				if (!recv_status.empty) begin
					read_valid_d = 1'b1;
					recv_pop     = advance;
					avail_d      = (recv_cnt_dn != '0);
					// XON goes out once each time the level falls under its threshold.
					if (recv_cnt_dn < CMPW'(xon_thr_q)) begin
						if (!resume_sent_q) begin
							urgent_valid_d  = 1'b1;
							urgent_value_d  = xon_code_q;
							sender_active_d = 1'b1;
							resume_sent_d   = 1'b1;
						end
					end else begin
						resume_sent_d = 1'b0;
					end
				end
			end
			default: begin
				overflow_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			urgent_valid_q  <= 1'b0;
			urgent_value_q  <= '0;
			sender_active_q <= 1'b1;
			resume_sent_q   <= 1'b0;
			valid_s2        <= 1'b0;
		end else begin
			if (advance) begin
				urgent_valid_q  <= urgent_valid_d;
				urgent_value_q  <= urgent_value_d;
				sender_active_q <= sender_active_d;
				resume_sent_q   <= resume_sent_d;
				valid_s2        <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Result flags load with the item; the urgent byte is parked in the send FIFO's
	// place by selecting it here when it was sent instead of a queued byte.
	logic          urgent_sent_s2;
	logic [BW-1:0] urgent_byte_s2;

	always_ff @(posedge clk) begin
		if (advance) begin
			send_valid_s2  <= send_valid_d;
			read_valid_s2  <= read_valid_d;
			write_acc_s2   <= write_acc_d;
			overflow_s2    <= overflow_d;
			avail_s2       <= avail_d;
			tx_req_s2      <= sender_active_d;
			urgent_sent_s2 <= (op_s1 == sfx_pkg::OP_TX_READY) && urgent_valid_q;
			urgent_byte_s2 <= urgent_value_q;
		end
	end

	sfx_fifo #(
		.DEPTH (SEND_DEPTH)
	) u_send_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (send_push),
		.pop    (send_pop),
		.wdata  (host_byte_s1),
		.rdata  (send_rdata),
		.count  (send_count),
		.status (send_status)
	);

	sfx_fifo #(
		.DEPTH (RECV_DEPTH)
	) u_recv_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (recv_push),
		.pop    (recv_pop),
		.wdata  (line_byte_s1),
		.rdata  (recv_rdata),
		.count  (recv_count),
		.status (recv_status)
	);

	logic [BW-1:0] send_byte_out;
	logic [BW-1:0] read_byte_out;

	// Bytes read as zero whenever their valid flag is low.
	always_comb begin
		send_byte_out = '0;
		if (send_valid_s2) begin
			send_byte_out = urgent_sent_s2 ? urgent_byte_s2 : send_rdata;
		end
		read_byte_out = read_valid_s2 ? recv_rdata : '0;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {
		2'b00,
		tx_req_s2,
		avail_s2,
		overflow_s2,
		write_acc_s2,
		read_byte_out,
		read_valid_s2,
		send_byte_out,
		send_valid_s2
	};

	// The send count is only needed through the full and empty flags.
	logic unused_send_count;
	assign unused_send_count = ^send_count;

endmodule

`default_nettype wire

>>> hw/rtl/sfx_checker.sv
`default_nettype none

// Port-level checks on the result channel.
module sfx_port_checks (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [sfx_pkg::M_TDATA_W-1:0] m_tdata
);

	// A result waiting for the sink stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat withdrawn while stalled");

	// One operation per beat: never both a transmitted byte and a host read.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[9]))
		else $error("send and read both valid in one beat");

	// A send byte with no valid flag is zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> (m_tdata[8:1] == '0))
		else $error("send byte nonzero without send_valid");

	// An accepted host write always reenables transmit requests.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[18] |-> m_tdata[21])
		else $error("write accepted but transmit request low");

	// A dropped byte means the receive FIFO was full, so data is available.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[19] |-> m_tdata[20])
		else $error("overflow reported with empty receive FIFO");

endmodule

bind serial_fifos_xon_xoff_unit sfx_port_checks u_sfx_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
